[rtl/mbrm_pkg.sv]
// shared types, register codes and constants of the breath-rate monitor
package mbrm_pkg;

    // fixed field widths
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;
    localparam int PIX_W       = 8;
    localparam int TS_W        = 32;
    localparam int FIELD_CNT_W = 20;
    localparam int FRAME_W     = 16;
    localparam int PERIOD_W    = 14;
    localparam int BPM_W       = 6;
    localparam int GAIN_CFG_W  = 16;
    localparam int RATE_W      = 16;
    localparam int DIV_CNT_W   = 4;
    localparam int REM_W       = 14;
    localparam int PER_SUM_W   = 18;
    localparam int GAP_SMALL_W = 14;
    localparam int RECIP_SHIFT = 19;

    // register reset values
    localparam logic [7:0]  THRESHOLD_RESET = 8'd50;
    localparam logic [19:0] CEILING_RESET   = 20'd40000;
    localparam logic [19:0] FLOOR_RESET     = 20'd4000;
    localparam logic [15:0] GAIN_RESET      = 16'd1311;
    localparam logic [19:0] BAND_RESET      = 20'd500;
    localparam logic [19:0] SWING_RESET     = 20'd700;
    localparam logic [15:0] STABLE_RESET    = 16'd120;
    localparam logic [15:0] ABSENT_RESET    = 16'd300;

    // state reset values and arithmetic constants
    localparam int unsigned    AVG_RESET    = 1500;
    localparam logic [13:0]    PERIOD_RESET = 14'd3000;
    localparam logic [5:0]     BPM_RESET    = 6'd20;
    localparam logic [5:0]     BPM_MAX      = 6'd40;
    localparam logic [15:0]    RATE_DIVIDEND = 16'd60000;
    localparam logic [31:0]    GAP_LOW      = 32'd1500;
    localparam logic [31:0]    GAP_HIGH     = 32'd12000;
    localparam logic [7:0]     PIXEL_ON     = 8'd255;
    localparam logic [15:0]    FRAMES_MAX   = 16'hFFFF;
    localparam int unsigned    LIMIT_SCALE  = 3;
    localparam int unsigned    SMOOTH_OLD   = 9;
    localparam int unsigned    RECIP_TEN    = 52429;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PIXEL_THRESHOLD = 3'd0,
        CFG_COUNT_CEILING   = 3'd1,
        CFG_COUNT_FLOOR     = 3'd2,
        CFG_AVERAGE_GAIN    = 3'd3,
        CFG_PRESENCE_BAND   = 3'd4,
        CFG_BREATH_SWING    = 3'd5,
        CFG_STABLE_FRAMES   = 3'd6,
        CFG_ABSENT_FRAMES   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0]  pixel_threshold;
        logic [19:0] count_ceiling;
        logic [19:0] count_floor;
        logic [15:0] average_gain;
        logic [19:0] presence_band;
        logic [19:0] breath_swing;
        logic [15:0] stable_frames;
        logic [15:0] absent_frames;
    } cfg_t;

    // frame sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_LIMIT,
        ST_DECIDE,
        ST_PER1,
        ST_PER2,
        ST_PER3,
        ST_DIV,
        ST_DONE
    } state_t;

    // shared unit operations
    typedef enum logic {
        ALU_MAC,
        ALU_SUB
    } alu_op_t;

    // one result item
    typedef struct packed {
        logic [7:0]  binary_pixel;
        logic        frame_done;
        logic [19:0] motion_count;
        logic [19:0] running_average;
        logic        refresh_reference;
        logic        subject_present;
        logic        subject_stable;
        logic        breath_detected;
        logic [31:0] breath_gap_ms;
        logic [5:0]  breaths_per_minute;
    } result_t;

endpackage

[rtl/mbrm_in_if.sv]
// pixel-pair input channel
interface mbrm_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  current_pixel;
    logic [7:0]  reference_pixel;
    logic        frame_end;
    logic [31:0] timestamp_ms;

    modport source (
        output valid, current_pixel, reference_pixel, frame_end, timestamp_ms,
        input  ready
    );
    modport sink (
        input  valid, current_pixel, reference_pixel, frame_end, timestamp_ms,
        output ready
    );
endinterface

[rtl/mbrm_out_if.sv]
// result output channel
interface mbrm_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  binary_pixel;
    logic        frame_done;
    logic [19:0] motion_count;
    logic [19:0] running_average;
    logic        refresh_reference;
    logic        subject_present;
    logic        subject_stable;
    logic        breath_detected;
    logic [31:0] breath_gap_ms;
    logic [5:0]  breaths_per_minute;

    modport source (
        output valid, binary_pixel, frame_done, motion_count, running_average,
               refresh_reference, subject_present, subject_stable,
               breath_detected, breath_gap_ms, breaths_per_minute,
        input  ready
    );
    modport sink (
        input  valid, binary_pixel, frame_done, motion_count, running_average,
               refresh_reference, subject_present, subject_stable,
               breath_detected, breath_gap_ms, breaths_per_minute,
        output ready
    );
endinterface

[rtl/mbrm_cfg.sv]
// configuration register bank
module mbrm_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [mbrm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mbrm_pkg::CFG_DATA_W-1:0]      cfg_data,
    output mbrm_pkg::cfg_t                       cfg
);

    mbrm_pkg::cfg_t cfg_reg;

    // register writes, masked to each register's width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_threshold <= mbrm_pkg::THRESHOLD_RESET;
            cfg_reg.count_ceiling   <= mbrm_pkg::CEILING_RESET;
            cfg_reg.count_floor     <= mbrm_pkg::FLOOR_RESET;
            cfg_reg.average_gain    <= mbrm_pkg::GAIN_RESET;
            cfg_reg.presence_band   <= mbrm_pkg::BAND_RESET;
            cfg_reg.breath_swing    <= mbrm_pkg::SWING_RESET;
            cfg_reg.stable_frames   <= mbrm_pkg::STABLE_RESET;
            cfg_reg.absent_frames   <= mbrm_pkg::ABSENT_RESET;
        end
        else if (cfg_we)
        begin
            case (mbrm_pkg::cfg_idx_t'(cfg_index))
                mbrm_pkg::CFG_PIXEL_THRESHOLD: cfg_reg.pixel_threshold <= cfg_data[7:0];
                mbrm_pkg::CFG_COUNT_CEILING:   cfg_reg.count_ceiling   <= cfg_data[19:0];
                mbrm_pkg::CFG_COUNT_FLOOR:     cfg_reg.count_floor     <= cfg_data[19:0];
                mbrm_pkg::CFG_AVERAGE_GAIN:    cfg_reg.average_gain    <= cfg_data[15:0];
                mbrm_pkg::CFG_PRESENCE_BAND:   cfg_reg.presence_band   <= cfg_data[19:0];
                mbrm_pkg::CFG_BREATH_SWING:    cfg_reg.breath_swing    <= cfg_data[19:0];
                mbrm_pkg::CFG_STABLE_FRAMES:   cfg_reg.stable_frames   <= cfg_data[15:0];
                mbrm_pkg::CFG_ABSENT_FRAMES:   cfg_reg.absent_frames   <= cfg_data[15:0];
                default:                       cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/mbrm_alu.sv]
// shared multiply-add and subtract unit
module mbrm_alu #(
    parameter int A_W = 18,
    parameter int B_W = 20,
    parameter int R_W = 39
) (
    input  mbrm_pkg::alu_op_t   op,
    input  logic [A_W-1:0]      a,
    input  logic [B_W-1:0]      b,
    input  logic [R_W-1:0]      c,
    output logic [R_W-1:0]      res
);

    logic [A_W+B_W-1:0] prod;

    // one multiplier, full-width product
    assign prod = a * b;

    // operation select; subtract leaves the borrow in the top bit
    always_comb
    begin
        case (op)
            mbrm_pkg::ALU_MAC: res = R_W'(prod) + c;
            mbrm_pkg::ALU_SUB: res = R_W'(a) - R_W'(b);
            default:           res = '0;
        endcase
    end

endmodule

[rtl/motion_breath_rate_monitor.sv]
// top level: pixel counter, frame sequencer and output register
// Breath-rate monitor fed by frame differencing.
// pixels: one current/reference pixel pair per item, frame_end on the last
// pixel of a frame, timestamp_ms read with that pixel.
// results: one item per pixel; binary_pixel always, the frame fields and
// frame_done only on the frame-end pixel, breaths_per_minute always.
// cfg_we/cfg_index/cfg_data write the eight registers, no read-back; write
// them only while no item is in flight.
// A pixel that does not end a frame is taken while the sequencer is idle and its
// result is in the output register on the next cycle; such pixels stream at one
// per clock while the receiver keeps up.
// A frame-end pixel runs through the shared multiply-add unit: two multiplies
// for the average, one for the limit, one decide step, output load; when a
// breath with a gap inside the bounds re-smooths the period, two more multiplies
// and a 16-step division for the rate come before the output load.
// pixels.ready is low during that sequence.
// A stalled receiver holds the result in the output register; a new item is
// taken only in the cycle the register empties or is already empty.
// Reset clears all counters and flags, the average to 1500, the period to
// 3000 ms (20 breaths per minute) and the registers to their defaults.
module motion_breath_rate_monitor #(
    parameter int COUNT_BITS     = 20,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    mbrm_in_if.sink                              pixels,
    mbrm_out_if.source                           results,
    input  logic                                 cfg_we,
    input  logic [mbrm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mbrm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int GAIN_W = GAIN_FRAC_BITS + 1;
    localparam int GC_W   = (GAIN_W > mbrm_pkg::GAIN_CFG_W) ? GAIN_W : mbrm_pkg::GAIN_CFG_W;
    localparam int A_W    = (GAIN_W > mbrm_pkg::PER_SUM_W) ? GAIN_W : mbrm_pkg::PER_SUM_W;
    localparam int B_W    = (COUNT_BITS > mbrm_pkg::RATE_W) ? COUNT_BITS : mbrm_pkg::RATE_W;
    localparam int R_W    = A_W + B_W + 1;
    localparam int CMP_W  = ((COUNT_BITS > mbrm_pkg::FIELD_CNT_W) ? COUNT_BITS
                             : mbrm_pkg::FIELD_CNT_W) + 2;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [GC_W-1:0]       GAIN_ONE  = GC_W'(1) << GAIN_FRAC_BITS;

    mbrm_pkg::cfg_t     cfg;
    mbrm_pkg::state_t   state_reg, state_next;
    mbrm_pkg::alu_op_t  alu_op;
    mbrm_pkg::result_t  res_reg, res_next;

    logic [A_W-1:0]     alu_a;
    logic [B_W-1:0]     alu_b;
    logic [R_W-1:0]     alu_c, alu_res;
    logic               alu_borrow;

    logic               out_valid_reg, out_load, out_free, accept;
    logic [COUNT_BITS-1:0] pixel_count_reg, count_inc, total_reg, average_count_reg;
    logic [mbrm_pkg::FRAME_W-1:0] still_frames_reg, low_motion_frames_reg;
    logic               stable_flag_reg, above_flag_reg, below_flag_reg;
    logic [mbrm_pkg::TS_W-1:0] breath_start_reg, ts_reg, gap_reg;
    logic [mbrm_pkg::PERIOD_W-1:0] period_reg;
    logic [mbrm_pkg::BPM_W-1:0] bpm_reg;
    logic [R_W-1:0]     acc_reg;
    logic [mbrm_pkg::PIX_W-1:0] bin_reg, bin_now;
    logic               refresh_reg, present_reg, breath_reg;
    logic [mbrm_pkg::REM_W-1:0] rem_reg;
    logic [mbrm_pkg::RATE_W-1:0] quo_reg, quo_last;
    logic [mbrm_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [mbrm_pkg::REM_W:0] rem_shift;

    logic [GC_W-1:0]    gain_sat;
    logic [GAIN_W-1:0]  gain, gain_rest;
    logic [8:0]         diff;
    logic               moving;

    // decide-step values
    logic [CMP_W-1:0]   limit_raw, limit_c, total_w, avg_w, dev_w, swing_w;
    logic               refresh_d, stable_set, stable_d, present_d, track;
    logic               above_t, below_t, breath_d, per_upd;
    logic [mbrm_pkg::FRAME_W-1:0] still_inc, still_d, low_d;
    logic [mbrm_pkg::TS_W-1:0] start_s, gap_d, start_d;

    mbrm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mbrm_alu #(
        .A_W (A_W),
        .B_W (B_W),
        .R_W (R_W)
    ) u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .c   (alu_c),
        .res (alu_res)
    );

    assign alu_borrow = alu_res[R_W-1];

    // pixel front end
    assign diff    = {1'b0, pixels.current_pixel} - {1'b0, pixels.reference_pixel};
    assign moving  = !diff[8] && (diff[7:0] > cfg.pixel_threshold);
    assign bin_now = moving ? mbrm_pkg::PIXEL_ON : '0;
    assign count_inc = (moving && (pixel_count_reg != COUNT_MAX))
                       ? pixel_count_reg + 1'b1 : pixel_count_reg;

    // handshake
    assign out_free     = !out_valid_reg || results.ready;
    assign pixels.ready = (state_reg == mbrm_pkg::ST_IDLE) && out_free;
    assign accept       = pixels.valid && pixels.ready;

    // gain clamped to one
    assign gain_sat  = (GC_W'(cfg.average_gain) > GAIN_ONE) ? GAIN_ONE
                       : GC_W'(cfg.average_gain);
    assign gain      = GAIN_W'(gain_sat);
    assign gain_rest = GAIN_W'(GAIN_ONE - gain_sat);

    // frame decisions from the new average and the tripled average
    always_comb
    begin
        limit_raw = CMP_W'(acc_reg);
        total_w   = CMP_W'(total_reg);
        avg_w     = CMP_W'(average_count_reg);
        swing_w   = CMP_W'(cfg.breath_swing);
        if (limit_raw > CMP_W'(cfg.count_ceiling))
            limit_c = CMP_W'(cfg.count_ceiling);
        else if (limit_raw < CMP_W'(cfg.count_floor))
            limit_c = CMP_W'(cfg.count_floor);
        else
            limit_c = limit_raw;
        refresh_d = total_w > limit_c;
        still_inc = (still_frames_reg != mbrm_pkg::FRAMES_MAX)
                    ? still_frames_reg + 1'b1 : still_frames_reg;
        still_d   = refresh_d ? '0 : still_inc;
        stable_set = (still_d > cfg.stable_frames) && !stable_flag_reg;
        if (stable_set)
            stable_d = 1'b1;
        else if (still_d <= cfg.stable_frames)
            stable_d = 1'b0;
        else
            stable_d = stable_flag_reg;
        start_s = stable_set ? ts_reg : breath_start_reg;
        dev_w   = (total_w > avg_w) ? total_w - avg_w : avg_w - total_w;
        if (dev_w < CMP_W'(cfg.presence_band))
            low_d = (low_motion_frames_reg != mbrm_pkg::FRAMES_MAX)
                    ? low_motion_frames_reg + 1'b1 : low_motion_frames_reg;
        else
            low_d = '0;
        present_d = low_d <= cfg.absent_frames;
        track     = stable_d && present_d;
        above_t   = above_flag_reg || (total_w > avg_w + swing_w);
        below_t   = below_flag_reg || (total_w + swing_w < avg_w);
        breath_d  = track && above_t && below_t;
        gap_d     = breath_d ? ts_reg - start_s : '0;
        start_d   = breath_d ? ts_reg : start_s;
        per_upd   = breath_d && (gap_d > mbrm_pkg::GAP_LOW) && (gap_d < mbrm_pkg::GAP_HIGH);
    end

    // divider step: next dividend bit into the remainder
    assign rem_shift = {rem_reg, mbrm_pkg::RATE_DIVIDEND[div_cnt_reg]};
    assign quo_last  = {quo_reg[mbrm_pkg::RATE_W-2:0], !alu_borrow};

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mbrm_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // sequencer: next state, shared unit operands, output load
    always_comb
    begin
        state_next = state_reg;
        alu_op     = mbrm_pkg::ALU_MAC;
        alu_a      = '0;
        alu_b      = '0;
        alu_c      = '0;
        out_load   = 1'b0;
        res_next   = '0;
        case (state_reg)
            mbrm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (pixels.frame_end)
                        state_next = mbrm_pkg::ST_MUL1;
                    else
                    begin
                        out_load = 1'b1;
                        res_next.binary_pixel       = bin_now;
                        res_next.breaths_per_minute = bpm_reg;
                    end
                end
            end
            mbrm_pkg::ST_MUL1:
            begin
                alu_a      = A_W'(gain);
                alu_b      = B_W'(total_reg);
                state_next = mbrm_pkg::ST_MUL2;
            end
            mbrm_pkg::ST_MUL2:
            begin
                alu_a      = A_W'(gain_rest);
                alu_b      = B_W'(average_count_reg);
                alu_c      = acc_reg;
                state_next = mbrm_pkg::ST_LIMIT;
            end
            mbrm_pkg::ST_LIMIT:
            begin
                alu_a      = A_W'(mbrm_pkg::LIMIT_SCALE);
                alu_b      = B_W'(average_count_reg);
                state_next = mbrm_pkg::ST_DECIDE;
            end
            mbrm_pkg::ST_DECIDE:
            begin
                state_next = per_upd ? mbrm_pkg::ST_PER1 : mbrm_pkg::ST_DONE;
            end
            mbrm_pkg::ST_PER1:
            begin
                alu_a      = A_W'(mbrm_pkg::SMOOTH_OLD);
                alu_b      = B_W'(period_reg);
                alu_c      = R_W'(gap_reg[mbrm_pkg::GAP_SMALL_W-1:0]);
                state_next = mbrm_pkg::ST_PER2;
            end
            mbrm_pkg::ST_PER2:
            begin
                alu_a      = A_W'(acc_reg[mbrm_pkg::PER_SUM_W-1:0]);
                alu_b      = B_W'(mbrm_pkg::RECIP_TEN);
                state_next = mbrm_pkg::ST_PER3;
            end
            mbrm_pkg::ST_PER3:
            begin
                state_next = mbrm_pkg::ST_DIV;
            end
            mbrm_pkg::ST_DIV:
            begin
                alu_op = mbrm_pkg::ALU_SUB;
                alu_a  = A_W'(rem_shift);
                alu_b  = B_W'(period_reg);
                if (div_cnt_reg == '0)
                    state_next = mbrm_pkg::ST_DONE;
            end
            mbrm_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = mbrm_pkg::ST_IDLE;
                    res_next.binary_pixel       = bin_reg;
                    res_next.frame_done         = 1'b1;
                    res_next.motion_count       = mbrm_pkg::FIELD_CNT_W'(total_reg);
                    res_next.running_average    = mbrm_pkg::FIELD_CNT_W'(average_count_reg);
                    res_next.refresh_reference  = refresh_reg;
                    res_next.subject_present    = present_reg;
                    res_next.subject_stable     = stable_flag_reg;
                    res_next.breath_detected    = breath_reg;
                    res_next.breath_gap_ms      = gap_reg;
                    res_next.breaths_per_minute = bpm_reg;
                end
            end
            default:
            begin
                state_next = mbrm_pkg::ST_IDLE;
            end
        endcase
    end

    // model state and control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg         <= 1'b0;
            pixel_count_reg       <= '0;
            average_count_reg     <= COUNT_BITS'(mbrm_pkg::AVG_RESET);
            still_frames_reg      <= '0;
            low_motion_frames_reg <= '0;
            stable_flag_reg       <= 1'b0;
            above_flag_reg        <= 1'b0;
            below_flag_reg        <= 1'b0;
            breath_start_reg      <= '0;
            period_reg            <= mbrm_pkg::PERIOD_RESET;
            bpm_reg               <= mbrm_pkg::BPM_RESET;
            div_cnt_reg           <= '0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                mbrm_pkg::ST_IDLE:
                begin
                    if (accept)
                        pixel_count_reg <= pixels.frame_end ? '0 : count_inc;
                end
                mbrm_pkg::ST_MUL2:
                begin
                    average_count_reg <= COUNT_BITS'(alu_res >> GAIN_FRAC_BITS);
                end
                mbrm_pkg::ST_DECIDE:
                begin
                    still_frames_reg      <= still_d;
                    low_motion_frames_reg <= low_d;
                    stable_flag_reg       <= stable_d;
                    above_flag_reg        <= track && above_t && !breath_d;
                    below_flag_reg        <= track && below_t && !breath_d;
                    breath_start_reg      <= start_d;
                end
                mbrm_pkg::ST_PER3:
                begin
                    period_reg  <= mbrm_pkg::PERIOD_W'(acc_reg >> mbrm_pkg::RECIP_SHIFT);
                    div_cnt_reg <= mbrm_pkg::DIV_CNT_W'(mbrm_pkg::RATE_W - 1);
                end
                mbrm_pkg::ST_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                    if (div_cnt_reg == '0)
                    begin
                        if (quo_last > mbrm_pkg::RATE_W'(mbrm_pkg::BPM_MAX))
                            bpm_reg <= mbrm_pkg::BPM_MAX;
                        else
                            bpm_reg <= quo_last[mbrm_pkg::BPM_W-1:0];
                    end
                end
                default:
                begin
                    div_cnt_reg <= div_cnt_reg;
                end
            endcase
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        if (out_load)
            res_reg <= res_next;
        case (state_reg)
            mbrm_pkg::ST_IDLE:
            begin
                if (accept && pixels.frame_end)
                begin
                    total_reg <= count_inc;
                    ts_reg    <= pixels.timestamp_ms;
                    bin_reg   <= bin_now;
                end
            end
            mbrm_pkg::ST_MUL1,
            mbrm_pkg::ST_MUL2,
            mbrm_pkg::ST_LIMIT,
            mbrm_pkg::ST_PER1,
            mbrm_pkg::ST_PER2:
            begin
                acc_reg <= alu_res;
            end
            mbrm_pkg::ST_DECIDE:
            begin
                refresh_reg <= refresh_d;
                present_reg <= present_d;
                breath_reg  <= breath_d;
                gap_reg     <= gap_d;
            end
            mbrm_pkg::ST_PER3:
            begin
                rem_reg <= '0;
                quo_reg <= '0;
            end
            mbrm_pkg::ST_DIV:
            begin
                quo_reg <= quo_last;
                if (!alu_borrow)
                    rem_reg <= alu_res[mbrm_pkg::REM_W-1:0];
                else
                    rem_reg <= rem_shift[mbrm_pkg::REM_W-1:0];
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    // output channel
    assign results.valid              = out_valid_reg;
    assign results.binary_pixel       = res_reg.binary_pixel;
    assign results.frame_done         = res_reg.frame_done;
    assign results.motion_count       = res_reg.motion_count;
    assign results.running_average    = res_reg.running_average;
    assign results.refresh_reference  = res_reg.refresh_reference;
    assign results.subject_present    = res_reg.subject_present;
    assign results.subject_stable     = res_reg.subject_stable;
    assign results.breath_detected    = res_reg.breath_detected;
    assign results.breath_gap_ms      = res_reg.breath_gap_ms;
    assign results.breaths_per_minute = res_reg.breaths_per_minute;

    // a frame-end item always starts the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        (pixels.valid && pixels.ready && pixels.frame_end) |=> (state_reg == mbrm_pkg::ST_MUL1))
    else $error("frame-end item did not start the frame sequence");

    // no item is taken while the sequencer is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != mbrm_pkg::ST_IDLE) |-> !pixels.ready)
    else $error("input ready while frame sequence runs");

    // the rate never leaves its range
    assert property (@(posedge clk) disable iff (!rst_n)
        bpm_reg <= mbrm_pkg::BPM_MAX)
    else $error("breath rate above its ceiling");

    // a breath is only reported for a still, present subject
    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.breath_detected)
            |-> (results.frame_done && results.subject_stable && results.subject_present))
    else $error("breath reported without stable presence");

endmodule

[tb/sv/tb_motion_breath_rate_monitor.sv]
// self-checking testbench of the breath-rate monitor: random pixel streams against a predictor
module tb_motion_breath_rate_monitor;
    timeunit 1ns;
    timeprecision 1ps;

    // widths the block is built with
    localparam int          COUNT_W    = 20;
    localparam int          GAIN_W     = 16;
    localparam logic [63:0] COUNT_FULL = (64'd1 << COUNT_W) - 64'd1;
    localparam logic [63:0] GAIN_ONE   = 64'd1 << GAIN_W;

    // one pixel pair waiting to be sent, with the idle cycles in front of it
    typedef struct {
        logic [7:0]  cur;
        logic [7:0]  ref_pix;
        logic        fend;
        logic [31:0] ts;
        int unsigned gap;
    } pixel_item_t;

    bit                                clk;
    logic                              rst_n;
    logic                              cfg_we;
    logic [mbrm_pkg::CFG_INDEX_W-1:0]  cfg_index;
    logic [mbrm_pkg::CFG_DATA_W-1:0]   cfg_data;

    mbrm_in_if  pix_if();
    mbrm_out_if res_if();

    motion_breath_rate_monitor #(
        .COUNT_BITS     (COUNT_W),
        .GAIN_FRAC_BITS (GAIN_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pix_if),
        .results   (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register copy and frame state of the predictor
    mbrm_pkg::cfg_t regs;
    logic [19:0]   moving_pixels;
    logic [19:0]   avg_level;
    logic [15:0]   still_run;
    logic [15:0]   quiet_run;
    logic          stable_on;
    logic          swing_up;
    logic          swing_down;
    logic [31:0]   breath_mark_ms;
    logic [13:0]   period_ms;

    // traffic bookkeeping
    pixel_item_t         pixel_queue[$];
    mbrm_pkg::result_t   expected_results[$];
    bit            pixel_taken;
    bit            result_taken;
    bit            tx_idle_on;
    bit            rx_idle_on;
    int unsigned   gap_count;
    int unsigned   stall_count;
    int unsigned   pixels_sent;
    int unsigned   pixels_taken;
    int unsigned   mismatches;
    int unsigned   frames_seen;
    int unsigned   breaths_seen;
    int unsigned   refreshes_seen;
    int unsigned   configs_loaded;
    logic [31:0]   frame_clock;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("tb_motion_breath_rate_monitor: errors");
        $finish;
    end

    // breaths per minute from the smoothed period
    function automatic logic [5:0] rate_of(logic [13:0] p);
        int unsigned q;
        if (p == '0)
            return mbrm_pkg::BPM_MAX;
        q = 32'(mbrm_pkg::RATE_DIVIDEND) / 32'(p);
        return (q > 32'(mbrm_pkg::BPM_MAX)) ? mbrm_pkg::BPM_MAX : 6'(q);
    endfunction

    // state after reset
    task automatic reset_model();
        regs.pixel_threshold = mbrm_pkg::THRESHOLD_RESET;
        regs.count_ceiling   = mbrm_pkg::CEILING_RESET;
        regs.count_floor     = mbrm_pkg::FLOOR_RESET;
        regs.average_gain    = mbrm_pkg::GAIN_RESET;
        regs.presence_band   = mbrm_pkg::BAND_RESET;
        regs.breath_swing    = mbrm_pkg::SWING_RESET;
        regs.stable_frames   = mbrm_pkg::STABLE_RESET;
        regs.absent_frames   = mbrm_pkg::ABSENT_RESET;
        moving_pixels  = '0;
        avg_level      = 20'(mbrm_pkg::AVG_RESET);
        still_run      = '0;
        quiet_run      = '0;
        stable_on      = 1'b0;
        swing_up       = 1'b0;
        swing_down     = 1'b0;
        breath_mark_ms = '0;
        period_ms      = mbrm_pkg::PERIOD_RESET;
    endtask

    // expected result of one pixel pair, frame arithmetic on the frame-end pixel
    function automatic mbrm_pkg::result_t predict_pixel(logic [7:0] cur, logic [7:0] ref_pix,
                                                        logic fend, logic [31:0] ts);
        mbrm_pkg::result_t r;
        logic        moving;
        logic        present;
        logic        breath;
        logic [63:0] total;
        logic [63:0] gain;
        logic [63:0] avg;
        logic [63:0] limit;
        logic [63:0] dev;
        logic [31:0] gap;
        r = '0;
        moving = (cur > ref_pix) && ((cur - ref_pix) > regs.pixel_threshold);
        r.binary_pixel = moving ? mbrm_pkg::PIXEL_ON : 8'd0;
        if (moving && moving_pixels != COUNT_FULL[19:0])
            moving_pixels++;
        r.breaths_per_minute = rate_of(period_ms);
        if (!fend)
            return r;

        // running average and large-movement limit
        total = 64'(moving_pixels);
        moving_pixels = '0;
        gain = (64'(regs.average_gain) > GAIN_ONE) ? GAIN_ONE : 64'(regs.average_gain);
        avg = ((gain * total + (GAIN_ONE - gain) * 64'(avg_level)) >> GAIN_W) & COUNT_FULL;
        avg_level = avg[19:0];
        limit = 64'(mbrm_pkg::LIMIT_SCALE) * avg;
        if (limit > 64'(regs.count_ceiling))
            limit = 64'(regs.count_ceiling);
        else if (limit < 64'(regs.count_floor))
            limit = 64'(regs.count_floor);

        // stillness
        if (still_run != mbrm_pkg::FRAMES_MAX)
            still_run++;
        if (total > limit)
        begin
            r.refresh_reference = 1'b1;
            still_run = '0;
        end
        if (still_run > regs.stable_frames && !stable_on)
        begin
            breath_mark_ms = ts;
            stable_on = 1'b1;
        end
        else if (still_run <= regs.stable_frames)
            stable_on = 1'b0;

        // presence
        dev = (total > avg) ? total - avg : avg - total;
        if (dev < 64'(regs.presence_band))
        begin
            if (quiet_run != mbrm_pkg::FRAMES_MAX)
                quiet_run++;
        end
        else
            quiet_run = '0;
        present = (quiet_run <= regs.absent_frames);

        // breath swing and period smoothing
        breath = 1'b0;
        gap = '0;
        if (stable_on && present)
        begin
            if (total > avg + 64'(regs.breath_swing))
                swing_up = 1'b1;
            if (total + 64'(regs.breath_swing) < avg)
                swing_down = 1'b1;
            if (swing_up && swing_down)
            begin
                swing_up = 1'b0;
                swing_down = 1'b0;
                breath = 1'b1;
                gap = ts - breath_mark_ms;
                breath_mark_ms = ts;
                if (gap > mbrm_pkg::GAP_LOW && gap < mbrm_pkg::GAP_HIGH)
                    period_ms = 14'((gap + mbrm_pkg::SMOOTH_OLD * 32'(period_ms)) / 32'd10);
            end
        end
        else
        begin
            swing_up = 1'b0;
            swing_down = 1'b0;
        end

        r.frame_done         = 1'b1;
        r.motion_count       = total[19:0];
        r.running_average    = avg[19:0];
        r.subject_present    = present;
        r.subject_stable     = stable_on;
        r.breath_detected    = breath;
        r.breath_gap_ms      = gap;
        r.breaths_per_minute = rate_of(period_ms);
        return r;
    endfunction

    // one field of a result against its prediction
    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // monitor: check results, then predict every accepted item
    always @(posedge clk)
    begin
        mbrm_pkg::result_t want;
        result_taken = rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1;
        pixel_taken  = rst_n && pix_if.valid === 1'b1 && pix_if.ready === 1'b1;
        if (result_taken)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: result expected none, got binary_pixel %0d frame_done %0d",
                         $time, res_if.binary_pixel, res_if.frame_done);
            end
            else
            begin
                want = expected_results.pop_front();
                frames_seen    += 32'(want.frame_done);
                breaths_seen   += 32'(want.breath_detected);
                refreshes_seen += 32'(want.refresh_reference);
                check_field("binary_pixel", 32'(want.binary_pixel),
                            32'(res_if.binary_pixel));
                check_field("frame_done", 32'(want.frame_done), 32'(res_if.frame_done));
                check_field("motion_count", 32'(want.motion_count),
                            32'(res_if.motion_count));
                check_field("running_average", 32'(want.running_average),
                            32'(res_if.running_average));
                check_field("refresh_reference", 32'(want.refresh_reference),
                            32'(res_if.refresh_reference));
                check_field("subject_present", 32'(want.subject_present),
                            32'(res_if.subject_present));
                check_field("subject_stable", 32'(want.subject_stable),
                            32'(res_if.subject_stable));
                check_field("breath_detected", 32'(want.breath_detected),
                            32'(res_if.breath_detected));
                check_field("breath_gap_ms", want.breath_gap_ms, res_if.breath_gap_ms);
                check_field("breaths_per_minute", 32'(want.breaths_per_minute),
                            32'(res_if.breaths_per_minute));
            end
        end
        if (pixel_taken)
        begin
            expected_results.push_back(predict_pixel(pix_if.current_pixel,
                                                     pix_if.reference_pixel,
                                                     pix_if.frame_end, pix_if.timestamp_ms));
            pixels_taken++;
        end
    end

    // driver: next item once the current one is taken and its idle cycles are spent
    always @(negedge clk)
    begin
        pixel_item_t next_item;
        if (!rst_n)
        begin
            pix_if.valid           <= 1'b0;
            pix_if.current_pixel   <= '0;
            pix_if.reference_pixel <= '0;
            pix_if.frame_end       <= 1'b0;
            pix_if.timestamp_ms    <= '0;
            gap_count <= 0;
        end
        else if (!pix_if.valid || pixel_taken)
        begin
            if (pixel_queue.size() == 0)
                pix_if.valid <= 1'b0;
            else if (gap_count < pixel_queue[0].gap)
            begin
                pix_if.valid <= 1'b0;
                gap_count <= gap_count + 1;
            end
            else
            begin
                next_item = pixel_queue.pop_front();
                pix_if.current_pixel   <= next_item.cur;
                pix_if.reference_pixel <= next_item.ref_pix;
                pix_if.frame_end       <= next_item.fend;
                pix_if.timestamp_ms    <= next_item.ts;
                pix_if.valid           <= 1'b1;
                gap_count <= 0;
            end
        end
    end

    // receiver: random stall after each result item while rx_idle_on is set
    always @(negedge clk)
    begin
        int unsigned stall;
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            stall_count <= 0;
        end
        else if (result_taken)
        begin
            stall = rx_idle_on ? $urandom_range(14, 0) : 0;
            stall_count <= stall;
            res_if.ready <= (stall == 0);
        end
        else if (stall_count > 0)
        begin
            stall_count <= stall_count - 1;
            res_if.ready <= (stall_count == 1);
        end
        else
            res_if.ready <= 1'b1;
    end

    // register write while the block is idle
    task automatic write_reg(mbrm_pkg::cfg_idx_t idx, logic [19:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            mbrm_pkg::CFG_PIXEL_THRESHOLD: regs.pixel_threshold = value[7:0];
            mbrm_pkg::CFG_COUNT_CEILING:   regs.count_ceiling   = value;
            mbrm_pkg::CFG_COUNT_FLOOR:     regs.count_floor     = value;
            mbrm_pkg::CFG_AVERAGE_GAIN:    regs.average_gain    = value[15:0];
            mbrm_pkg::CFG_PRESENCE_BAND:   regs.presence_band   = value;
            mbrm_pkg::CFG_BREATH_SWING:    regs.breath_swing    = value;
            mbrm_pkg::CFG_STABLE_FRAMES:   regs.stable_frames   = value[15:0];
            mbrm_pkg::CFG_ABSENT_FRAMES:   regs.absent_frames   = value[15:0];
            default:                       ;
        endcase
    endtask

    // full register set, unused upper data bits random
    task automatic load_regs(logic [7:0] thr, logic [19:0] ceiling_v, logic [19:0] floor_v,
                             logic [15:0] gain, logic [19:0] band, logic [19:0] swing,
                             logic [15:0] stable_n, logic [15:0] absent_n);
        write_reg(mbrm_pkg::CFG_PIXEL_THRESHOLD, {12'($urandom()), thr});
        write_reg(mbrm_pkg::CFG_COUNT_CEILING, ceiling_v);
        write_reg(mbrm_pkg::CFG_COUNT_FLOOR, floor_v);
        write_reg(mbrm_pkg::CFG_AVERAGE_GAIN, {4'($urandom()), gain});
        write_reg(mbrm_pkg::CFG_PRESENCE_BAND, band);
        write_reg(mbrm_pkg::CFG_BREATH_SWING, swing);
        write_reg(mbrm_pkg::CFG_STABLE_FRAMES, {4'($urandom()), stable_n});
        write_reg(mbrm_pkg::CFG_ABSENT_FRAMES, {4'($urandom()), absent_n});
        configs_loaded++;
    endtask

    // wait until every sent item has its result, then let the block settle
    task automatic wait_idle();
        while (pixels_taken != pixels_sent || expected_results.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    // hand one item to the driver, keeping the pending queue short
    task automatic queue_pixel(logic [7:0] cur, logic [7:0] ref_pix, logic fend,
                               logic [31:0] ts);
        pixel_item_t it;
        while (pixel_queue.size() >= 64)
            @(negedge clk);
        it.cur     = cur;
        it.ref_pix = ref_pix;
        it.fend    = fend;
        it.ts      = ts;
        it.gap     = tx_idle_on ? $urandom_range(14, 0) : 0;
        pixel_queue.push_back(it);
        pixels_sent++;
    endtask

    // frame of len pixels, about hits of them moving under the current threshold
    task automatic queue_frame(int unsigned len, int unsigned hits);
        int unsigned thr;
        int unsigned cp;
        int unsigned rp;
        bit          moving;
        bit          last;
        thr = 32'(regs.pixel_threshold);
        for (int unsigned i = 0; i < len; i++)
        begin
            moving = $urandom_range(len - 1, 0) < hits;
            last = (i == len - 1);
            if (moving && thr < 255)
            begin
                rp = $urandom_range(254 - thr, 0);
                cp = $urandom_range(255, rp + thr + 1);
            end
            else if (!moving)
            begin
                cp = $urandom_range(255, 0);
                rp = $urandom_range(255, (cp > thr) ? cp - thr : 0);
            end
            else
            begin
                cp = $urandom_range(255, 0);
                rp = $urandom_range(255, 0);
            end
            // mostly breath-like frame spacing, now and then a long gap
            if (last)
                frame_clock += ($urandom_range(19, 0) == 0) ? $urandom_range(30000, 12000)
                                                            : $urandom_range(2500, 300);
            queue_pixel(8'(cp), 8'(rp), last, last ? frame_clock : $urandom());
        end
    endtask

    // a few busy frames followed by a few quiet ones
    task automatic queue_breath_cycle();
        int unsigned n;
        int unsigned len;
        n = $urandom_range(3, 1);
        repeat (n)
        begin
            len = $urandom_range(6, 3);
            queue_frame(len, len);
        end
        n = $urandom_range(3, 1);
        repeat (n)
            queue_frame($urandom_range(4, 1), 0);
    endtask

    // stimulus
    initial
    begin
        int unsigned round_end;
        bit          paused;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = mbrm_pkg::CFG_PIXEL_THRESHOLD;
        cfg_data = '0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        frame_clock = '0;
        reset_model();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // pixel extremes and threshold edges under reset settings
        queue_pixel(8'd255, 8'd0, 1'b0, 32'hFFFF_FFFF);
        queue_pixel(8'd0, 8'd255, 1'b0, 32'h0);
        queue_pixel(8'd50, 8'd0, 1'b0, 32'h5555_5555);
        queue_pixel(8'd51, 8'd0, 1'b0, 32'hAAAA_AAAA);
        queue_pixel(8'd128, 8'd128, 1'b0, 32'h0);
        queue_pixel(8'd255, 8'd255, 1'b1, 32'h0);
        queue_pixel(8'd0, 8'd0, 1'b1, 32'hFFFF_FFFF);
        queue_pixel(8'd200, 8'd149, 1'b0, 32'h1234_5678);
        queue_pixel(8'd1, 8'd0, 1'b1, 32'h0000_1234);
        queue_pixel(8'd255, 8'd204, 1'b1, 32'h8000_0000);
        queue_pixel(8'd254, 8'd203, 1'b0, 32'h7FFF_FFFF);
        queue_pixel(8'd0, 8'd0, 1'b1, 32'h8000_1000);

        // random rounds, register extremes first, then breath-like settings
        for (int k = 0; k < 8; k++)
        begin
            wait_idle();
            case (k)
                0: load_regs(8'd0, 20'd0, 20'd0, 16'd0, 20'd0, 20'd0, 16'd0, 16'd0);
                1: load_regs(8'd255, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, 20'hFFFFF, 20'hFFFFF,
                             16'hFFFF, 16'hFFFF);
                default:
                    load_regs(8'($urandom_range(80, 0)),
                              ($urandom_range(3, 0) == 0) ? 20'($urandom_range(30, 0))
                                                          : 20'($urandom_range(20'hFFFFF, 40)),
                              20'($urandom_range(60, 10)),
                              16'($urandom_range(45000, 6000)),
                              (k % 2 == 0) ? 20'd0 : 20'($urandom_range(6, 0)),
                              20'($urandom_range(2, 0)),
                              16'($urandom_range(4, 0)),
                              16'($urandom_range(30, 0)));
            endcase
            frame_clock = (k == 3) ? 32'hFFFF_C000 : $urandom();
            round_end = pixels_sent + ((k < 2) ? 60 : 160);
            paused = 1'b0;
            while (pixels_sent < round_end)
            begin
                tx_idle_on = ($urandom_range(2, 0) != 0);
                rx_idle_on = ($urandom_range(2, 0) != 0);
                // sender holds back until every result is in
                if (!paused && pixels_sent + 80 > round_end)
                begin
                    wait_idle();
                    paused = 1'b1;
                end
                if ($urandom_range(3, 0) != 0)
                    queue_breath_cycle();
                else
                    repeat ($urandom_range(6, 1))
                        queue_pixel(8'($urandom()), 8'($urandom()),
                                    $urandom_range(5, 0) == 0, $urandom());
            end
        end

        wait_idle();
        $display("run covered %0d pixel items, %0d frame ends, %0d breaths, %0d refreshes",
                 pixels_taken, frames_seen, breaths_seen, refreshes_seen);
        $display("over %0d register settings, %0d mismatching fields",
                 configs_loaded, mismatches);
        if (mismatches == 0)
            $display("tb_motion_breath_rate_monitor: clean");
        else
            $display("tb_motion_breath_rate_monitor: errors");
        $finish;
    end

endmodule
